>>> rtl/dfpe_pkg.sv
package dfpe_pkg;

  localparam int unsigned NumSegments = 33;
  localparam int unsigned SegW = $clog2(NumSegments);

  typedef logic [SegW-1:0] seg_t;

  localparam seg_t SegLast = seg_t'(NumSegments - 1);

  localparam logic [15:0] MinBitCycles = 16'd25;

  typedef enum logic [1:0] {
    RegBitCycles   = 2'd0,
    RegMinThrottle = 2'd1,
    RegMaxThrottle = 2'd2
  } reg_idx_e;

  localparam logic [15:0] BitCyclesReset   = 16'd222;
  localparam logic [10:0] MinThrottleReset = 11'd48;
  localparam logic [10:0] MaxThrottleReset = 11'd2047;

endpackage

>>> rtl/dshot_frame_pulse_encoder_core.sv
// Flow: the first segment of a frame passes the clamp, frame/timing, serializer and output
// registers, then one segment per cycle follows while the output is taken.
// Frames: the serializer loads the next frame only as the last segment of the current one is taken.
// Pipeline: clamp stage, frame/timing stage, then the 33-step serializer.
// Reset: async active low; clears all valid bits and loads the register reset values.
module dshot_frame_pulse_encoder_core
  import dfpe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] throttle_i,
  input  logic        telemetry_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        level_o,
  output logic [16:0] duration_o,
  output logic [15:0] frame_word_o,
  output logic        last_o
);

  // configuration registers
  logic [15:0] bit_cycles_q;
  logic [10:0] min_thr_q, max_thr_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cycles_q <= BitCyclesReset;
      min_thr_q    <= MinThrottleReset;
      max_thr_q    <= MaxThrottleReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegBitCycles:   bit_cycles_q <= pwdata[15:0];
        RegMinThrottle: min_thr_q    <= pwdata[10:0];
        RegMaxThrottle: max_thr_q    <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegBitCycles:   prdata = {16'd0, bit_cycles_q};
      RegMinThrottle: prdata = {21'd0, min_thr_q};
      RegMaxThrottle: prdata = {21'd0, max_thr_q};
      default:        prdata = 32'd0;
    endcase
  end

  // stage handshake
  logic v1_q, v2_q, v3_q, ov_q;
  logic rdy1, rdy2, rdy3, adv;
  seg_t seg_q;

  assign adv  = v3_q && (!ov_q || out_ready_i);
  assign rdy3 = !v3_q || (adv && seg_q == SegLast);
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // stage 1: clamp throttle, floor bit period
  logic [10:0] thr1_q;
  logic        tlm1_q;
  logic [15:0] t1_q;
  logic [15:0] thr_lo;
  logic [10:0] thr_cl;

  always_comb begin
    thr_lo = (throttle_i < {5'd0, min_thr_q}) ? {5'd0, min_thr_q} : throttle_i;
    thr_cl = (thr_lo > {5'd0, max_thr_q}) ? max_thr_q : thr_lo[10:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (rdy1) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      thr1_q <= thr_cl;
      tlm1_q <= telemetry_i;
      t1_q   <= (bit_cycles_q < MinBitCycles) ? MinBitCycles : bit_cycles_q;
    end
  end

  // stage 2: frame word and segment timings
  logic [15:0] frame2_q, hi1_2_q, hi0_2_q, lo1_2_q, lo0_2_q;
  logic [16:0] gap2_q;
  logic [11:0] payload;
  logic [17:0] t3;
  logic [15:0] hi1, hi0;

  always_comb begin
    payload = {thr1_q, tlm1_q};
    t3      = {1'b0, t1_q, 1'b0} + {2'b00, t1_q};
    hi1     = t3[17:2];
    hi0     = {1'b0, t3[17:3]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (rdy2) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      frame2_q <= {payload, payload[3:0] ^ payload[7:4] ^ payload[11:8]};
      hi1_2_q  <= hi1;
      hi0_2_q  <= hi0;
      lo1_2_q  <= t1_q - hi1;
      lo0_2_q  <= t1_q - hi0;
      gap2_q   <= {t1_q, 1'b0};
    end
  end

  // stage 3: serializer
  logic [15:0] frame3_q, hi1_3_q, hi0_3_q, lo1_3_q, lo0_3_q;
  logic [16:0] gap3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q  <= 1'b0;
      seg_q <= '0;
    end else if (rdy3) begin
      v3_q  <= v2_q;
      seg_q <= '0;
    end else if (adv) begin
      seg_q <= seg_q + seg_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      frame3_q <= frame2_q;
      hi1_3_q  <= hi1_2_q;
      hi0_3_q  <= hi0_2_q;
      lo1_3_q  <= lo1_2_q;
      lo0_3_q  <= lo0_2_q;
      gap3_q   <= gap2_q;
    end
  end

  logic        seg_bit, seg_lvl, seg_last;
  logic [16:0] seg_dur;
  logic [3:0]  bit_idx;

  always_comb begin
    bit_idx  = 4'd15 - seg_q[4:1];
    seg_bit  = frame3_q[bit_idx];
    seg_last = (seg_q == SegLast);
    seg_lvl  = !seg_last && !seg_q[0];
    if (seg_last) seg_dur = gap3_q;
    else if (seg_lvl) seg_dur = {1'b0, seg_bit ? hi1_3_q : hi0_3_q};
    else seg_dur = {1'b0, seg_bit ? lo1_3_q : lo0_3_q};
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (!ov_q || out_ready_i) ov_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      level_o      <= seg_lvl;
      duration_o   <= seg_dur;
      frame_word_o <= frame3_q;
      last_o       <= seg_last;
    end
  end

  assign out_valid_o = ov_q;

  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> seg_q <= SegLast)
    else $error("segment counter out of range");

  a_gap_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> !level_o)
    else $error("gap segment driven high");

  a_dur_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duration_o != 17'd0)
    else $error("zero length segment");

  a_in_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("input transfer lost");

endmodule
